// ===== rtl/core/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEQ_DEPTH = 16;
   localparam int DATA_W    = 32;
   localparam int REQ_W     = 3;
   localparam int STATUS_W  = 2;

   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH_FRONT = 3'd0,
      REQ_PUSH_BACK  = 3'd1,
      REQ_POP_FRONT  = 3'd2,
      REQ_POP_BACK   = 3'd3,
      REQ_READ_FWD   = 3'd4,
      REQ_READ_REV   = 3'd5
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_SHIFT_UP,
      OP_SHIFT_DOWN,
      OP_LOAD_BACK,
      OP_ROT_DOWN,
      OP_ROT_UP
   } cell_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

// ===== rtl/core/deq_if.sv =====
// ----------------------------------------------------------------------------
// deq_req_if / deq_rsp_if
// Valid/ready channels for queue requests and queue results.
// ----------------------------------------------------------------------------
interface deq_req_if import deq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [REQ_W-1:0]         req_type;
   logic signed [DATA_W-1:0] push_value;

   modport source (output valid, output req_type, output push_value, input ready);
   modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] item_value;
   logic [STATUS_W-1:0]      status;
   logic                     last;

   modport source (output valid, output item_value, output status, output last,
                   input ready);
   modport sink   (input valid, input item_value, input status, input last,
                   output ready);
endinterface

// ===== rtl/core/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Outside a read-out, cell k holds the word k places from the front. Push and
// pop at either end complete one word per cycle while the result side keeps
// up. A read-out first latches the stored count and direction, then sends
// one stored entry per cycle while the result side keeps up, and holds the
// request side until its last entry is registered: the row rotates by one
// cell per entry sent and the front or back cell is sent, so after a full
// pass the queue is back in its original order. Empty reads, refused pushes
// and empty pops give a single result. Request codes 6 and 7 are accepted
// and give no result.
module double_ended_queue import deq_pkg::*; #(
   parameter int DEPTH = DEQ_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   deq_req_if.sink    req_ch,
   deq_rsp_if.source  rsp_ch
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   cell_op_type              op;
   logic [CNT_W-1:0]         count;
   logic signed [DATA_W-1:0] cell_data [DEPTH];
   logic signed [DATA_W-1:0] back_sel  [DEPTH];
   logic signed [DATA_W-1:0] front_data;
   logic signed [DATA_W-1:0] back_data;
   logic signed [DATA_W-1:0] head_in;

   deq_ctrl #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .front_data (front_data),
      .back_data  (back_data),
      .op         (op),
      .count      (count)
   );

   assign front_data = cell_data[0];
   assign head_in    = (op == OP_ROT_UP) ? back_data : req_ch.push_value;

   always_comb begin
      back_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         back_data = back_data | back_sel[i];
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [DATA_W-1:0] lo_in;
      logic signed [DATA_W-1:0] hi_in;

      if (g == 0) begin : g_first
         assign lo_in = head_in;
      end else begin : g_mid
         assign lo_in = cell_data[g-1];
      end

      if (g == DEPTH - 1) begin : g_end
         assign hi_in = '0;
      end else begin : g_inner
         assign hi_in = cell_data[g+1];
      end

      deq_cell #(
         .IDX   (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .count      (count),
         .push_value (req_ch.push_value),
         .lo_in      (lo_in),
         .hi_in      (hi_in),
         .front_data (front_data),
         .data       (cell_data[g]),
         .back_sel   (back_sel[g])
      );
   end

endmodule

// ===== rtl/core/deq_cell.sv =====
// ----------------------------------------------------------------------------
// deq_cell
// One queue slot: holds the word at its position from the front and moves it
// to or from its neighbors as the row operation commands.
// ----------------------------------------------------------------------------
module deq_cell import deq_pkg::*; #(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  logic                     clock,
   input  cell_op_type              op,
   input  logic [CNT_W-1:0]         count,
   input  logic signed [DATA_W-1:0] push_value,
   input  logic signed [DATA_W-1:0] lo_in,
   input  logic signed [DATA_W-1:0] hi_in,
   input  logic signed [DATA_W-1:0] front_data,
   output logic signed [DATA_W-1:0] data,
   output logic signed [DATA_W-1:0] back_sel
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;
   logic                     is_back;
   logic                     is_slot;

   assign is_back = (count == CNT_W'(IDX + 1));
   assign is_slot = (count == CNT_W'(IDX));

   always_comb begin
      data_in = data_ff;
      case (op)
         OP_SHIFT_UP:   data_in = lo_in;
         OP_SHIFT_DOWN: data_in = hi_in;
         OP_LOAD_BACK:  if (is_slot) data_in = push_value;
         OP_ROT_DOWN:   data_in = is_back ? front_data : hi_in;
         OP_ROT_UP:     data_in = lo_in;
         default:       data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign back_sel = is_back ? data_ff : '0;

endmodule

// ===== rtl/core/deq_ctrl.sv =====
// ----------------------------------------------------------------------------
// deq_ctrl
// Request decode, entry count, read-out sequencing and result register.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; #(
   parameter int DEPTH = DEQ_DEPTH,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   deq_req_if.sink                  req_ch,
   deq_rsp_if.source                rsp_ch,
   input  logic signed [DATA_W-1:0] front_data,
   input  logic signed [DATA_W-1:0] back_data,
   output cell_op_type              op,
   output logic [CNT_W-1:0]         count
);

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         remain_ff, remain_in;
   logic                     rev_ff, rev_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic         out_free;
   logic         accept;
   logic         full;
   logic         empty;
   req_code_type code;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign accept   = req_ch.valid && req_ch.ready;
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign code     = req_code_type'(req_ch.req_type);

   assign req_ch.ready = (state_ff == ST_IDLE) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !empty &&
                (code == REQ_READ_FWD || code == REQ_READ_REV))
               state_in = ST_READ;
         end
         ST_READ: begin
            if (out_free && remain_ff == CNT_W'(1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op            = OP_HOLD;
      count_in      = count_ff;
      remain_in     = remain_ff;
      rev_in        = rev_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = ST_OK;
               rsp_last_in   = 1'b1;
               unique case (code) inside
                  REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        op       = (code == REQ_PUSH_FRONT) ? OP_SHIFT_UP : OP_LOAD_BACK;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  REQ_POP_FRONT, REQ_POP_BACK: begin
                     if (empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        if (code == REQ_POP_FRONT) begin
                           op           = OP_SHIFT_DOWN;
                           rsp_value_in = front_data;
                        end else begin
                           rsp_value_in = back_data;
                        end
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  REQ_READ_FWD, REQ_READ_REV: begin
                     if (empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        remain_in    = count_ff;
                        rev_in       = (code == REQ_READ_REV);
                     end
                  end
                  default: rsp_valid_in = 1'b0;
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               op            = rev_ff ? OP_ROT_UP : OP_ROT_DOWN;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rev_ff ? back_data : front_data;
               rsp_status_in = ST_OK;
               rsp_last_in   = (remain_ff == CNT_W'(1));
               remain_in     = remain_ff - CNT_W'(1);
            end
         end
         default: op = OP_HOLD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rev_ff       <= rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign count             = count_ff;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.item_value = rsp_value_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.last       = rsp_last_ff;

endmodule

// ===== sim/deq_checker.sv =====
// ----------------------------------------------------------------------------
// deq_checker
// Watches the request and result channels of the double-ended queue, keeps
// its own copy of the stored words, predicts the result words of every
// accepted request and compares each accepted result with the oldest one.
// ----------------------------------------------------------------------------
module deq_checker import deq_pkg::*; (
   input  logic clock,
   input  logic reset,
   deq_req_if   req_mon,
   deq_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EXP_SLOTS = 256;

   typedef struct packed {
      logic signed [DATA_W-1:0] item_value;
      status_type               status;
      logic                     last;
   } deq_result_type;

   logic signed [DATA_W-1:0] model_words [DEQ_DEPTH];
   int                       model_count;
   deq_result_type           exp_ring [EXP_SLOTS];
   int                       exp_head;
   int                       exp_tail;
   int                       exp_count;

   function automatic deq_result_type make_result(logic signed [DATA_W-1:0] value,
                                                  status_type st, logic last);
      deq_result_type r;
      r.item_value = value;
      r.status     = st;
      r.last       = last;
      return r;
   endfunction

   function automatic void add_expected(deq_result_type r);
      exp_ring[exp_tail] = r;
      exp_tail           = (exp_tail + 1) % EXP_SLOTS;
      exp_count++;
   endfunction

   function automatic void predict_request(logic [REQ_W-1:0] code,
                                           logic signed [DATA_W-1:0] value);
      int n;
      int idx;
      n = model_count;
      case (code) inside
         REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
            if (n >= DEQ_DEPTH) begin
               add_expected(make_result('0, ST_FULL, 1'b1));
            end else begin
               if (code == REQ_PUSH_FRONT) begin
                  for (int i = n; i > 0; i--) model_words[i] = model_words[i-1];
                  model_words[0] = value;
               end else begin
                  model_words[n] = value;
               end
               model_count = n + 1;
               add_expected(make_result('0, ST_OK, 1'b1));
            end
         end
         REQ_POP_FRONT, REQ_POP_BACK: begin
            if (n == 0) begin
               add_expected(make_result('0, ST_EMPTY, 1'b1));
            end else if (code == REQ_POP_FRONT) begin
               add_expected(make_result(model_words[0], ST_OK, 1'b1));
               for (int i = 0; i < n - 1; i++) model_words[i] = model_words[i+1];
               model_count = n - 1;
            end else begin
               add_expected(make_result(model_words[n-1], ST_OK, 1'b1));
               model_count = n - 1;
            end
         end
         REQ_READ_FWD, REQ_READ_REV: begin
            if (n == 0) begin
               add_expected(make_result('0, ST_EMPTY, 1'b1));
            end else begin
               for (int i = 0; i < n; i++) begin
                  idx = (code == REQ_READ_FWD) ? i : n - 1 - i;
                  add_expected(make_result(model_words[idx], ST_OK, (i == n - 1)));
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void flag_mismatch(string what, deq_result_type want,
                                         deq_result_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t mismatch, %s: expected value %0d status %0d last %0d,",
                  $realtime, what, want.item_value, want.status, want.last);
         $display("   got value %0d status %0d last %0d",
                  got.item_value, got.status, got.last);
      end
   endfunction

   always @(posedge clock) begin : watch
      deq_result_type got;
      deq_result_type want;
      if (reset) begin
         model_count     = 0;
         exp_head        = 0;
         exp_tail        = 0;
         exp_count       = 0;
         fail_count      = 0;
         pending_results = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.item_value = rsp_mon.item_value;
            got.status     = status_type'(rsp_mon.status);
            got.last       = rsp_mon.last;
            if (exp_count == 0) begin
               flag_mismatch("result word with nothing expected", '0, got);
            end else begin
               want      = exp_ring[exp_head];
               exp_head  = (exp_head + 1) % EXP_SLOTS;
               exp_count--;
               if (got.item_value !== want.item_value || got.status !== want.status ||
                   got.last !== want.last) begin
                  flag_mismatch("result word", want, got);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_request(req_mon.req_type, req_mon.push_value);
         end
         pending_results = exp_count;
      end
   end

endmodule

// ===== sim/tb_double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Drives the double-ended queue with a directed set of requests and then
// random phases, a push-only one first and then ones biased toward filling,
// draining, mixing or reading out, with bursty requests and a stalling
// result side, and gives the verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
   timeunit 1ns;
   timeprecision 1ps;

   import deq_pkg::*;

   localparam int          CLOCK_PERIOD = 20;
   localparam int          RANDOM_ITEMS = 250;
   localparam int          PHASE_ITEMS  = 32;
   localparam int          DRAIN_CYCLES = 2 * DEQ_DEPTH + 10;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned HOLD_START   = 400;
   localparam int unsigned LONG_HOLD    = 300;

   localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
   localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

   localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] WORD_ONES = -32'sd1;

   localparam int PHASE_FILL  = 0;
   localparam int PHASE_DRAIN = 1;
   localparam int PHASE_MIX   = 2;
   localparam int PHASE_READ  = 3;
   localparam int PHASE_PUSH  = 4;

   logic        clock = 1'b0;
   logic        reset;
   int          fail_count;
   int          pending_results;
   int unsigned cycle_count = 0;
   int          burst_left = 0;

   deq_req_if req_ch ();
   deq_rsp_if rsp_ch ();

   double_ended_queue i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   deq_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // hold off for a long stretch once, otherwise cycle through stall patterns
   initial begin : rsp_stall
      int unsigned tick;
      tick = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (tick >= HOLD_START && tick < HOLD_START + LONG_HOLD) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            case ((tick / 150) % 3)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
               default: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   task automatic send_request(input logic [REQ_W-1:0] code,
                               input logic signed [DATA_W-1:0] value);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
      end
      burst_left--;
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= code;
      req_ch.push_value <= value;
      @(posedge clock iff req_ch.ready);
      @(negedge clock);
   endtask

   initial begin : stimulus
      int                       issued;
      int                       phase_kind;
      int                       push_pct;
      int                       read_pct;
      int                       roll;
      logic [REQ_W-1:0]         code;
      logic signed [DATA_W-1:0] value;

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.req_type   = REQ_PUSH_FRONT;
      req_ch.push_value = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty queue: every pop and read is refused
      send_request(REQ_READ_FWD, '0);
      send_request(REQ_READ_REV, '0);
      send_request(REQ_POP_FRONT, '0);
      send_request(REQ_POP_BACK, '0);
      // extremes at both ends
      send_request(REQ_PUSH_FRONT, WORD_MAX);
      send_request(REQ_PUSH_BACK, WORD_MIN);
      send_request(REQ_PUSH_FRONT, '0);
      send_request(REQ_PUSH_BACK, WORD_ONES);
      send_request(REQ_READ_FWD, '0);
      send_request(REQ_READ_REV, '0);
      send_request(REQ_SPARE_LO, WORD_ONES);
      send_request(REQ_SPARE_HI, WORD_MAX);
      send_request(REQ_POP_FRONT, '0);
      send_request(REQ_POP_BACK, '0);
      // drop to one entry, pop it to empty, then reuse the emptied queue
      send_request(REQ_POP_BACK, '0);
      send_request(REQ_POP_FRONT, '0);
      send_request(REQ_PUSH_BACK, 32'sh1234_5678);
      send_request(REQ_READ_REV, '0);
      send_request(REQ_POP_FRONT, '0);
      send_request(REQ_READ_FWD, '0);

      issued     = 0;
      phase_kind = PHASE_PUSH;
      while (issued < RANDOM_ITEMS) begin
         if (issued > 0 && issued % PHASE_ITEMS == 0) phase_kind = $urandom_range(0, 3);
         case (phase_kind)
            PHASE_FILL:  begin push_pct = 70; read_pct = 6;  end
            PHASE_DRAIN: begin push_pct = 20; read_pct = 6;  end
            PHASE_MIX:   begin push_pct = 45; read_pct = 10; end
            PHASE_READ:  begin push_pct = 30; read_pct = 40; end
            default:     begin push_pct = 100; read_pct = 0; end
         endcase
         roll = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 3) begin
            code = ($urandom_range(0, 1) == 0) ? REQ_SPARE_LO : REQ_SPARE_HI;
         end else if (roll < push_pct) begin
            code = ($urandom_range(0, 1) == 0) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
            issued++;
         end else if (roll < push_pct + read_pct) begin
            code = ($urandom_range(0, 1) == 0) ? REQ_READ_FWD : REQ_READ_REV;
            issued++;
         end else begin
            code = ($urandom_range(0, 1) == 0) ? REQ_POP_FRONT : REQ_POP_BACK;
            issued++;
         end
         case ($urandom_range(0, 7))
            0:       value = WORD_MAX;
            1:       value = WORD_MIN;
            2:       value = '0;
            3:       value = WORD_ONES;
            default: value = $urandom;
         endcase
         send_request(code, value);
      end
      req_ch.valid <= 1'b0;

      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
